FILE: rtl/core/dstq_pkg.sv
// Shared types and constants for the deadline sorted timer queue.
package dstq_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int TIME_BITS_DEF = 48;
	localparam int NEXT_BITS     = 48;
	localparam logic [15:0] SLACK_RESET = 16'd200;

	typedef enum logic [1:0] {
		OP_ADD  = 2'd0,
		OP_RUN  = 2'd1,
		OP_DEL  = 2'd2,
		OP_SETI = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_EXPIRED   = 3'd0,
		ST_RUN_DONE  = 3'd1,
		ST_ADDED     = 3'd2,
		ST_FULL      = 3'd3,
		ST_DELETED   = 3'd4,
		ST_NOT_FOUND = 3'd5,
		ST_IVL_SET   = 3'd6,
		ST_IVL_MISS  = 3'd7
	} status_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [7:0]  timer_id;
		logic [31:0] delay_ticks;
		logic        repeat_req;
		logic [47:0] now;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  expired_id;
		logic [47:0] next_delay;
		logic        last;
	} out_item_t;

endpackage

FILE: rtl/core/deadline_sorted_timer_queue.sv
// Top level of the deadline sorted timer queue: sequencer around the entry memory.
// Add, delete and set interval search one entry per cycle; each shifted entry is read, then
// written at its neighbor. A run scans each entry in a read and a write state, emits one
// expiry per cycle while the output is not stalled and reinserts each repeating one like an add.
// Throughput: one operation at a time; the next transfer waits for the last result.
// Reset clears the entry count and restores slack_ticks to 200; the memory is not cleared.
module deadline_sorted_timer_queue
	import dstq_pkg::*;
#(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [15:0] cfg_data
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = TIME_BITS + 32 + 8 + 1;
	localparam logic [TIME_BITS-1:0] TMAX = '1;

	typedef struct packed {
		logic [TIME_BITS-1:0] deadline;
		logic [31:0]          interval;
		logic [7:0]           id;
		logic                 rep;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE, S_FIND, S_FIND_W, S_SHIFT_R, S_SHIFT_W, S_PUT, S_SETI,
		S_RUN_R, S_RUN_W, S_EMIT, S_CMP_R, S_CMP_W, S_HEAD_R, S_HEAD_W, S_OUT
	} state_t;

	state_t           state_q;
	in_item_t         req_q;
	logic [15:0]      slack_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    k_q;
	logic [CW-1:0]    ri_q;
	logic [CW-1:0]    pos_q;
	logic             del_q;
	logic             torun_q;
	entry_t           ins_q;
	logic [TIME_BITS-1:0] t_q;
	entry_t           fired_q [DEPTH];
	out_item_t        out_q;
	logic             out_v_q;

	logic             we;
	logic [AW-1:0]    waddr, raddr;
	entry_t           wdata, rd;
	logic [EW-1:0]    rbits;

	dstq_store #(.DEPTH(DEPTH), .WIDTH(EW)) u_store (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rbits)
	);
	assign rd = entry_t'(rbits);

	function automatic logic [TIME_BITS-1:0] sat_add(logic [TIME_BITS-1:0] a,
		logic [31:0] b);
		logic [TIME_BITS:0] s;
		s = {1'b0, a} + {{(TIME_BITS-31){1'b0}}, b};
		return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
	endfunction

	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS:0]   diff;
	logic                 rd_expired;
	logic [TIME_BITS-1:0] hd;
	logic [TIME_BITS:0]   hdiff;
	logic                 find_more;

	// The time field may be wider or narrower than 48 bits; truncate or extend.
	always_comb begin
		now_t = '0;
		for (int b = 0; b < TIME_BITS; b++) begin
			if (b < 48) now_t[b] = req_q.now[b];
		end
		diff = {1'b0, rd.deadline} - {1'b0, t_q};
		rd_expired = (rd.deadline <= t_q) ||
			(diff[TIME_BITS-1:0] <= {{(TIME_BITS-16){1'b0}}, slack_q});
		hd = rd.deadline;
		hdiff = {1'b0, hd} - {1'b0, t_q};
		// The search goes on past the entry that is being looked at.
		if (op_t'(req_q.operation) == OP_ADD || op_t'(req_q.operation) == OP_RUN) begin
			find_more = (idx_q < count_q) && (rd.deadline <= ins_q.deadline);
		end else begin
			find_more = (idx_q < count_q) && (rd.id != req_q.timer_id);
		end
	end

	assign in_ready  = (state_q == S_IDLE) && !out_v_q;
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_v_q;
	assign out_data  = out_q;

	// Memory port control; the read data for an address arrives on the next cycle.
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rd;
		raddr = idx_q[AW-1:0];
		unique case (state_q)
			// While the search goes on, the next entry is fetched.
			S_FIND_W: if (find_more) raddr = AW'(idx_q + CW'(1));
			S_SHIFT_W: begin
				we = 1'b1;
				if (del_q) waddr = AW'(idx_q - CW'(1));
				else       waddr = AW'(idx_q + CW'(1));
			end
			S_RUN_W: begin
				we = (k_q != '0);
				waddr = AW'(idx_q - k_q);
			end
			S_PUT: begin
				we = 1'b1;
				waddr = pos_q[AW-1:0];
				wdata = ins_q;
			end
			S_SETI: begin
				we = 1'b1;
				wdata = rd;
				wdata.interval = req_q.delay_ticks;
			end
			S_HEAD_R: raddr = '0;
			default: ;
		endcase
	end

	function automatic out_item_t mk(status_t st, logic [7:0] id,
		logic [47:0] nd, logic lst);
		out_item_t o;
		o.status = st; o.expired_id = id; o.next_delay = nd; o.last = lst;
		return o;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			slack_q <= SLACK_RESET;
			count_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (out_v_q && out_ready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_valid) slack_q <= cfg_data;
					if (in_valid && in_ready) begin
						req_q <= in_data;
						idx_q <= '0;
						unique case (op_t'(in_data.operation))
							OP_ADD: begin
								state_q <= S_FIND;
								del_q   <= 1'b0;
							end
							OP_RUN: begin
								k_q <= '0;
								state_q <= S_HEAD_R;
								torun_q <= 1'b1;
							end
							default: begin
								state_q <= S_FIND;
								del_q   <= 1'b1;
							end
						endcase
					end
				end
				// Search: add looks for the insert point, delete and set interval for the id.
				S_FIND: begin
					if (op_t'(req_q.operation) == OP_ADD) begin
						ins_q.deadline <= sat_add(now_t, req_q.delay_ticks);
						ins_q.interval <= req_q.delay_ticks;
						ins_q.id  <= req_q.timer_id;
						ins_q.rep <= req_q.repeat_req;
						if (count_q >= CW'(DEPTH)) begin
							out_q <= mk(ST_FULL, req_q.timer_id, '0, 1'b1);
							state_q <= S_OUT;
						end else begin
							state_q <= S_FIND_W;
						end
					end else if (idx_q >= count_q) begin
						out_q <= mk(op_t'(req_q.operation) == OP_DEL ? ST_NOT_FOUND
							: ST_IVL_MISS, req_q.timer_id, '0, 1'b1);
						state_q <= S_OUT;
					end else begin
						state_q <= S_FIND_W;
					end
				end
				S_FIND_W: begin
					if (op_t'(req_q.operation) == OP_ADD || op_t'(req_q.operation) == OP_RUN)
					begin
						if (idx_q >= count_q || rd.deadline > ins_q.deadline) begin
							pos_q <= idx_q;
							if (idx_q == count_q) begin
								state_q <= S_PUT;
							end else begin
								idx_q <= count_q - CW'(1);
								state_q <= S_SHIFT_R;
							end
						end else begin
							idx_q <= idx_q + CW'(1);
							state_q <= S_FIND_W;
						end
					end else if (idx_q >= count_q) begin
						out_q <= mk(op_t'(req_q.operation) == OP_DEL ? ST_NOT_FOUND
							: ST_IVL_MISS, req_q.timer_id, '0, 1'b1);
						state_q <= S_OUT;
					end else if (rd.id == req_q.timer_id) begin
						if (op_t'(req_q.operation) == OP_SETI) begin
							state_q <= S_SETI;
						end else begin
							idx_q <= idx_q + CW'(1);
							state_q <= S_SHIFT_R;
						end
					end else begin
						idx_q <= idx_q + CW'(1);
					end
				end
				// Shift entries one at a time: read, then write at the neighbor.
				S_SHIFT_R: begin
					if (del_q && idx_q >= count_q) begin
						count_q <= count_q - CW'(1);
						out_q <= mk(ST_DELETED, req_q.timer_id, '0, 1'b1);
						state_q <= S_OUT;
					end else begin
						state_q <= S_SHIFT_W;
					end
				end
				S_SHIFT_W: begin
					if (del_q) begin
						idx_q <= idx_q + CW'(1);
						state_q <= S_SHIFT_R;
					end else if (idx_q == pos_q) begin
						state_q <= S_PUT;
					end else begin
						idx_q <= idx_q - CW'(1);
						state_q <= S_SHIFT_R;
					end
				end
				S_PUT: begin
					count_q <= count_q + CW'(1);
					if (op_t'(req_q.operation) == OP_RUN) begin
						ri_q <= ri_q + CW'(1);
						state_q <= S_CMP_R;
					end else begin
						out_q <= mk(ST_ADDED, req_q.timer_id, '0, 1'b1);
						state_q <= S_OUT;
					end
				end
				S_SETI: begin
					out_q <= mk(ST_IVL_SET, req_q.timer_id, '0, 1'b1);
					state_q <= S_OUT;
				end
				// Run: fetch head to settle the run time and scan expiries; later, to report the next delay.
				S_HEAD_R: begin
					if (count_q == '0 && torun_q) begin
						out_q <= mk(ST_RUN_DONE, '0, '0, 1'b1);
						state_q <= S_OUT;
					end else begin
						state_q <= S_HEAD_W;
					end
				end
				S_HEAD_W: begin
					if (torun_q) begin
						torun_q <= 1'b0;
						t_q <= (now_t == '0) ? rd.deadline : now_t;
						idx_q <= '0;
						state_q <= S_RUN_R;
					end else if (!out_v_q || out_ready) begin
						// The last expiry must have left the output register first.
						logic [47:0] nd;
						nd = '0;
						if (now_t != '0 && count_q != '0) begin
							if (hd <= t_q) nd = 48'd1;
							else if (TIME_BITS > 48 && |(hdiff[TIME_BITS-1:0] >> 48))
								nd = '1;
							else nd = 48'(hdiff[TIME_BITS-1:0]);
						end
						out_q <= mk(ST_RUN_DONE, '0, nd, 1'b1);
						state_q <= S_OUT;
					end
				end
				S_RUN_R: begin
					if (idx_q >= count_q) begin
						count_q <= count_q - k_q;
						ri_q <= '0;
						idx_q <= '0;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_RUN_W;
					end
				end
				// Each entry read is either taken as expired or moved down by k.
				S_RUN_W: begin
					if (k_q == idx_q && rd_expired) begin
						fired_q[k_q[AW-1:0]] <= rd;
						k_q <= k_q + CW'(1);
					end
					idx_q <= idx_q + CW'(1);
					state_q <= S_RUN_R;
				end
				S_EMIT: begin
					if (!out_v_q || out_ready) begin
						if (idx_q < k_q) begin
							out_q <= mk(ST_EXPIRED, fired_q[idx_q[AW-1:0]].id, '0, 1'b0);
							out_v_q <= 1'b1;
							idx_q <= idx_q + CW'(1);
						end else begin
							state_q <= S_CMP_R;
						end
					end
				end
				// Reinsert repeating expiries in order through the add path.
				S_CMP_R: begin
					if (ri_q >= k_q) begin
						state_q <= S_HEAD_R;
					end else if (!fired_q[ri_q[AW-1:0]].rep) begin
						ri_q <= ri_q + CW'(1);
					end else begin
						ins_q <= fired_q[ri_q[AW-1:0]];
						ins_q.deadline <= sat_add(fired_q[ri_q[AW-1:0]].deadline,
							fired_q[ri_q[AW-1:0]].interval);
						del_q <= 1'b0;
						idx_q <= '0;
						state_q <= S_CMP_W;
					end
				end
				S_CMP_W: state_q <= S_FIND_W;
				S_OUT: begin
					if (!out_v_q || out_ready) begin
						out_v_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH)) else $error("entry count exceeds depth");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("accepted while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result changed while stalled");
`endif

endmodule

FILE: rtl/core/dstq_store.sv
// Entry memory of the timer queue: one write port, one registered read port.
module dstq_store #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 89
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
